[hdl/pid_with_deadzone_and_error_filter_macros.svh]
// Assertion macros shared by the PID controller RTL.
`ifndef PID_WITH_DEADZONE_AND_ERROR_FILTER_MACROS_SVH
`define PID_WITH_DEADZONE_AND_ERROR_FILTER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PIDF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pidf assertion failed");

// Next-cycle implication, disabled in reset.
`define PIDF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pidf assertion failed");

`endif

[hdl/pidf_pkg.sv]
// Package with shared types and constants of the PID controller.
`timescale 1ns / 1ps
package pidf_pkg;

    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int ALPHA_W     = 13;
    localparam int DZ_W        = 11;
    localparam int MAXI_W      = 16;
    localparam int MAXO_W      = 15;
    localparam int DRIVE_W     = 16;
    localparam int DIGIT_W     = 4;
    localparam int GAIN_DIGITS = GAIN_W / DIGIT_W;
    localparam int DIG_CNT_W   = $clog2(GAIN_DIGITS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(4096);

    localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT  = 3'd6;

    localparam logic [GAIN_W-1:0]  RST_KP       = 16'd3277;
    localparam logic [GAIN_W-1:0]  RST_KI       = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_KD       = 16'd410;
    localparam logic [ALPHA_W-1:0] RST_ALPHA    = 13'd2458;
    localparam logic [DZ_W-1:0]    RST_DEADZONE = 11'd40;
    localparam logic [MAXI_W-1:0]  RST_MAX_INT  = 16'd1000;
    localparam logic [MAXO_W-1:0]  RST_MAX_OUT  = 15'd4000;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [ALPHA_W-1:0] lp_weight;
        logic [DZ_W-1:0]    deadzone;
        logic [MAXI_W-1:0]  integ_limit;
        logic [MAXO_W-1:0]  max_out;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic clr;
        logic step;
    } t_mac_ctl;

endpackage

[hdl/pidf_cfg.sv]
// Configuration register bank of the PID controller.
`timescale 1ns / 1ps
module pidf_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pidf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pidf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pidf_pkg::t_cfg                    o_cfg
);
    import pidf_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp          <= RST_KP;
            r_cfg.ki          <= RST_KI;
            r_cfg.kd          <= RST_KD;
            r_cfg.lp_weight   <= RST_ALPHA;
            r_cfg.deadzone    <= RST_DEADZONE;
            r_cfg.integ_limit <= RST_MAX_INT;
            r_cfg.max_out     <= RST_MAX_OUT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KP:       r_cfg.kp          <= i_cfg_data[GAIN_W-1:0];
                REG_KI:       r_cfg.ki          <= i_cfg_data[GAIN_W-1:0];
                REG_KD:       r_cfg.kd          <= i_cfg_data[GAIN_W-1:0];
                REG_ALPHA:    r_cfg.lp_weight   <= i_cfg_data[ALPHA_W-1:0];
                REG_DEADZONE: r_cfg.deadzone    <= i_cfg_data[DZ_W-1:0];
                REG_MAX_INT:  r_cfg.integ_limit <= i_cfg_data[MAXI_W-1:0];
                REG_MAX_OUT:  r_cfg.max_out     <= i_cfg_data[MAXO_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[hdl/pidf_mac.sv]
// Digit-serial multiply-accumulate unit, one gain digit per cycle while loaded or stepped.
`timescale 1ns / 1ps
module pidf_mac #(
    parameter int ACC_W = 47
) (
    input  logic                            i_clk,
    input  pidf_pkg::t_mac_ctl              i_ctl,
    input  logic signed [ACC_W-1:0]         i_op,
    input  logic [pidf_pkg::GAIN_W-1:0]     i_gain,
    output logic signed [ACC_W-1:0]         o_acc
);
    import pidf_pkg::*;

    logic signed [ACC_W-1:0]         r_op;
    logic [GAIN_W-1:0]               r_gain;
    logic [ACC_W-1:0]                r_acc;
    logic signed [ACC_W-1:0]         w_op;
    logic [GAIN_W-1:0]               w_gain;
    logic [ACC_W-1:0]                w_base;
    logic signed [ACC_W+DIGIT_W:0]   w_prod;
    logic [ACC_W-1:0]                n_acc;

    always_comb begin
        w_op   = i_ctl.load ? i_op : r_op;
        w_gain = i_ctl.load ? i_gain : r_gain;
        w_base = (i_ctl.load && i_ctl.clr) ? '0 : r_acc;
        w_prod = w_op * $signed({1'b0, w_gain[DIGIT_W-1:0]});
        n_acc  = w_base + w_prod[ACC_W-1:0];
    end

    // Shift multiplicand up and gain down by one digit per beat of work.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load || i_ctl.step) begin
            r_acc  <= n_acc;
            r_op   <= w_op <<< DIGIT_W;
            r_gain <= w_gain >> DIGIT_W;
        end
    end

    assign o_acc = $signed(r_acc);

endmodule

[hdl/pid_with_deadzone_and_error_filter.sv]
// Top level of the PID controller with error deadband and low-pass filter.
// Each compute beat sends five products through one shared digit-serial
// multiply-accumulate unit, then passes the update states and the limit state; the
// limit state waits until the output register is free. Input is taken only while
// idle; a finished result waits in the output register. Reset (synchronous, active
// low) zeroes filter, integral and last error state and loads the default gains and
// limits.
`timescale 1ns / 1ps
`include "pid_with_deadzone_and_error_filter_macros.svh"
module pid_with_deadzone_and_error_filter #(
    parameter int FRAC_BITS   = 12,
    parameter int ERROR_WIDTH = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((ERROR_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,  // error_sample
    input  logic                                  i_s_axis_tuser,  // cmd
    // master stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [pidf_pkg::DRIVE_W-1:0]          o_m_axis_tdata,  // drive
    output logic                                  o_m_axis_tuser,  // saturated
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pidf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pidf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import pidf_pkg::*;

    localparam int FW    = ERROR_WIDTH + FRAC_BITS;
    localparam int IW    = FRAC_BITS + MAXI_W + 1;
    localparam int ISW   = IW + 1;
    localparam int DW    = FW + 1;
    localparam int ACC_W = FRAC_BITS + ((ERROR_WIDTH > 16) ? ERROR_WIDTH : 16) + 19;
    localparam int EXT_W = ((ERROR_WIDTH > DZ_W) ? ERROR_WIDTH : DZ_W) + 1;
    localparam int OSH   = GAIN_FRAC + FRAC_BITS;

    localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(GAIN_DIGITS - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FA   = 4'd1;
    localparam logic [3:0] ST_FB   = 4'd2;
    localparam logic [3:0] ST_UPD1 = 4'd3;
    localparam logic [3:0] ST_UPD2 = 4'd4;
    localparam logic [3:0] ST_MP   = 4'd5;
    localparam logic [3:0] ST_MI   = 4'd6;
    localparam logic [3:0] ST_MD   = 4'd7;
    localparam logic [3:0] ST_SAT  = 4'd8;
    localparam logic [3:0] ST_CLR  = 4'd9;

    t_cfg                          w_cfg;
    t_mac_ctl                      w_mac_ctl;
    logic [3:0]                    r_state;
    logic [DIG_CNT_W-1:0]          r_dig;
    logic signed [ERROR_WIDTH-1:0] r_err;
    logic signed [FW-1:0]          r_filt;
    logic signed [FW-1:0]          r_prev;
    logic signed [IW-1:0]          r_integ;
    logic signed [ISW-1:0]         r_isum;
    logic signed [DW-1:0]          r_diff;
    logic                          r_m_tvalid;
    logic [DRIVE_W-1:0]            r_m_tdata;
    logic                          r_m_tuser;

    logic                          w_in_acc;
    logic                          w_in_mac;
    logic                          w_out_free;
    logic signed [ERROR_WIDTH-1:0] w_e_in;
    logic signed [EXT_W-1:0]       w_e_x;
    logic signed [EXT_W-1:0]       w_dz_x;
    logic                          w_in_dz;
    logic [ALPHA_W-1:0]            w_alpha;
    logic [ALPHA_W-1:0]            w_alpha_c;
    logic signed [ACC_W-1:0]       w_op;
    logic [GAIN_W-1:0]             w_gain;
    logic signed [ACC_W-1:0]       w_acc;
    logic signed [FW-1:0]          w_f;
    logic signed [ISW-1:0]         w_ilim;
    logic signed [ACC_W-1:0]       w_olim;
    logic signed [DRIVE_W-1:0]     w_maxo;
    logic signed [DRIVE_W-1:0]     w_drive;
    logic                          w_sat;
    logic [3:0]                    n_state;

    pidf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pidf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_op   (w_op),
        .i_gain (w_gain),
        .o_acc  (w_acc)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

    always_comb begin
        w_in_acc   = i_s_axis_tvalid && (r_state == ST_IDLE);
        w_in_mac   = (r_state == ST_FA) || (r_state == ST_FB) || (r_state == ST_MP)
                     || (r_state == ST_MI) || (r_state == ST_MD);
        w_out_free = !r_m_tvalid || i_m_axis_tready;

        w_e_in  = $signed(i_s_axis_tdata[ERROR_WIDTH-1:0]);
        w_e_x   = EXT_W'(w_e_in);
        w_dz_x  = $signed({{(EXT_W-DZ_W){1'b0}}, w_cfg.deadzone});
        w_in_dz = (w_e_x > -w_dz_x) && (w_e_x < w_dz_x);

        w_alpha   = (w_cfg.lp_weight > ALPHA_ONE) ? ALPHA_ONE : w_cfg.lp_weight;
        w_alpha_c = ALPHA_ONE - w_alpha;

        w_mac_ctl.load = w_in_mac && (r_dig == '0);
        w_mac_ctl.step = w_in_mac && (r_dig != '0);
        w_mac_ctl.clr  = (r_state == ST_FA) || (r_state == ST_MP);

        case (r_state)
            ST_FA: begin
                w_op   = ACC_W'(r_err) <<< FRAC_BITS;
                w_gain = GAIN_W'(w_alpha);
            end
            ST_FB: begin
                w_op   = ACC_W'(r_filt);
                w_gain = GAIN_W'(w_alpha_c);
            end
            ST_MP: begin
                w_op   = ACC_W'(r_filt);
                w_gain = w_cfg.kp;
            end
            ST_MI: begin
                w_op   = ACC_W'(r_integ);
                w_gain = w_cfg.ki;
            end
            ST_MD: begin
                w_op   = ACC_W'(r_diff);
                w_gain = w_cfg.kd;
            end
            default: begin
                w_op   = '0;
                w_gain = '0;
            end
        endcase

        w_f    = FW'(w_acc >>> GAIN_FRAC);
        w_ilim = $signed(ISW'({w_cfg.integ_limit, {FRAC_BITS{1'b0}}}));
        w_olim = $signed(ACC_W'({w_cfg.max_out, {OSH{1'b0}}}));
        w_maxo = $signed({1'b0, w_cfg.max_out});

        if (w_acc > w_olim) begin
            w_drive = w_maxo;
            w_sat   = 1'b1;
        end else if (w_acc < -w_olim) begin
            w_drive = -w_maxo;
            w_sat   = 1'b1;
        end else begin
            w_drive = DRIVE_W'(w_acc >>> OSH);
            w_sat   = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = i_s_axis_tuser ? ST_CLR : ST_FA;
                end
            end
            ST_FA:   if (r_dig == DIG_LAST) n_state = ST_FB;
            ST_FB:   if (r_dig == DIG_LAST) n_state = ST_UPD1;
            ST_UPD1: n_state = ST_UPD2;
            ST_UPD2: n_state = ST_MP;
            ST_MP:   if (r_dig == DIG_LAST) n_state = ST_MI;
            ST_MI:   if (r_dig == DIG_LAST) n_state = ST_MD;
            ST_MD:   if (r_dig == DIG_LAST) n_state = ST_SAT;
            ST_SAT:  if (w_out_free) n_state = ST_IDLE;
            ST_CLR:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dig   <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_mac) begin
                r_dig <= (r_dig == DIG_LAST) ? '0 : r_dig + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt  <= '0;
            r_prev  <= '0;
            r_integ <= '0;
        end else if (w_in_acc && i_s_axis_tuser) begin
            r_filt  <= '0;
            r_prev  <= '0;
            r_integ <= '0;
        end else if (r_state == ST_UPD1) begin
            r_filt <= w_f;
            r_prev <= w_f;
        end else if (r_state == ST_UPD2) begin
            if (r_isum > w_ilim) begin
                r_integ <= IW'(w_ilim);
            end else if (r_isum < -w_ilim) begin
                r_integ <= IW'(-w_ilim);
            end else begin
                r_integ <= IW'(r_isum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err <= w_in_dz ? '0 : w_e_in;
        end
        if (r_state == ST_UPD1) begin
            r_isum <= ISW'(r_integ) + ISW'(w_f);
            r_diff <= DW'(w_f) - DW'(r_prev);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if ((r_state == ST_SAT || r_state == ST_CLR) && w_out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SAT && w_out_free) begin
            r_m_tdata <= w_drive;
            r_m_tuser <= w_sat;
        end else if (r_state == ST_CLR && w_out_free) begin
            r_m_tdata <= '0;
            r_m_tuser <= 1'b0;
        end
    end

    `PIDF_ASSERT_NXT(a_accept_busy, w_in_acc, r_state != ST_IDLE)
    `PIDF_ASSERT_IMP(a_dig_in_mac, r_dig != '0, w_in_mac)
    `PIDF_ASSERT_NXT(a_md_to_sat, r_state == ST_MD && r_dig == DIG_LAST, r_state == ST_SAT)
    `PIDF_ASSERT_IMP(a_out_src, $rose(r_m_tvalid), $past(r_state == ST_SAT || r_state == ST_CLR))

endmodule
